>>> rtl/slgm_pkg.sv
// Package: types, constants and sine table for the stereo LFO gain modulator.
`default_nettype none
package slgm_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int SINE_DEPTH  = 256;
   localparam int IDX_BITS    = $clog2(SINE_DEPTH + 1);
   localparam int ROM_BITS    = $clog2(SINE_DEPTH);
   localparam int GAIN_BITS   = 17;
   localparam int MCAND_BITS  = SAMPLE_BITS + GAIN_BITS;
   localparam int PROD_BITS   = MCAND_BITS + GAIN_BITS;
   localparam logic [GAIN_BITS-1:0] UNITY = 17'd65536;

   localparam logic [2:0] REG_PHASE_INC  = 3'd0;
   localparam logic [2:0] REG_WAVE_SHAPE = 3'd1;
   localparam logic [2:0] REG_DEPTH      = 3'd2;
   localparam logic [2:0] REG_PHASE_OFS  = 3'd3;
   localparam logic [2:0] REG_DRY_GAIN   = 3'd4;
   localparam logic [2:0] REG_WET_GAIN   = 3'd5;
   localparam logic [2:0] REG_GLIDE      = 3'd6;

   localparam logic [1:0] SHAPE_SINE     = 2'd0;
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
   localparam logic [1:0] SHAPE_SAW      = 2'd2;
   localparam logic [1:0] SHAPE_SQUARE   = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] phase_increment;
      logic [1:0]  wave_shape;
      logic [16:0] depth;
      logic [31:0] phase_offset;
      logic [16:0] dry_gain;
      logic [16:0] wet_gain;
      logic [15:0] glide_coeff;
   } cfg_type;

   // Q30 Taylor sine, rounded to Q16; evaluated at elaboration for table constants
   function automatic logic [16:0] sine_of_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] r;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) + 64'd8192) >> 14;
      return (r > 64'd65536) ? UNITY : r[16:0];
   endfunction

   function automatic logic [16:0] sine_entry(input logic [IDX_BITS-1:0] k);
      return sine_of_q30((64'd1686629713 * 64'(k)) / 64'(SINE_DEPTH));
   endfunction

   // top entry of the quarter wave, kept outside the table
   localparam logic [16:0] SINE_TOP = sine_entry(IDX_BITS'(SINE_DEPTH));

endpackage
`default_nettype wire

>>> rtl/slgm_lfo.sv
// LFO: phase to dip (Q16) for one channel phase, shape selected by register.
`default_nettype none
module slgm_lfo
   import slgm_pkg::*;
(
   input  wire logic [31:0] phase,
   input  wire logic [1:0]  wave_shape,
   output logic      [16:0] dip
);
   logic [1:0]          quad;
   logic [IDX_BITS-1:0] idx;
   logic [IDX_BITS-1:0] tidx;
   logic [16:0]         sval;
   logic [17:0]         cosv;   // two's complement of +/- 65536
   logic [17:0]         diff;
   logic [32:0]         negph;
   logic [16:0]         sine_rom [0:SINE_DEPTH-1];

   // quarter-wave table, constants fixed at elaboration
   for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_sine
      localparam logic [16:0] ENTRY = sine_entry(IDX_BITS'(k));
      assign sine_rom[k] = ENTRY;
   end

   always_comb begin
      quad  = phase[31:30];
      idx   = IDX_BITS'((64'(phase[29:0]) * 64'(SINE_DEPTH)) >> 30);
      tidx  = (quad[0] == 1'b0) ? IDX_BITS'(SINE_DEPTH) - idx : idx;
      sval  = (tidx == IDX_BITS'(SINE_DEPTH)) ? SINE_TOP : sine_rom[tidx[ROM_BITS-1:0]];
      cosv  = (quad == 2'd0 || quad == 2'd3) ? {1'b0, sval} : -{1'b0, sval};
      diff  = 18'(UNITY) - cosv;
      negph = 33'h1_0000_0000 - {1'b0, phase};
      case (wave_shape)
         SHAPE_TRIANGLE: dip = phase[31] ? 17'(negph >> 15) : 17'(phase >> 15);
         SHAPE_SAW:      dip = {1'b0, phase[31:16]};
         SHAPE_SQUARE:   dip = phase[31] ? UNITY : 17'd0;
         default:        dip = diff[17:1];
      endcase
   end
endmodule
`default_nettype wire

>>> rtl/slgm_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle (LSB first).
`default_nettype none
module slgm_serial_mul
   import slgm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic signed [MCAND_BITS-1:0] mcand,
   input  wire logic [16:0] mplier,
   output logic             done,
   output logic signed [PROD_BITS-1:0] product
);
   logic signed [PROD_BITS-1:0] acc_ff, acc_in;
   logic signed [PROD_BITS-1:0] sh_ff, sh_in;
   logic [16:0]        mp_ff, mp_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;

   always_comb begin
      acc_in = acc_ff; sh_in = sh_ff; mp_in = mp_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      done = 1'b0;
      if (start) begin
         acc_in = '0; sh_in = PROD_BITS'(mcand); mp_in = mplier;
         cnt_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + sh_ff;
         sh_in  = sh_ff <<< 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end
   assign product = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      mp_ff  <= mp_in;
   end
endmodule
`default_nettype wire

>>> rtl/stereo_lfo_gain_modulator_core.sv
// Top level: stereo LFO tremolo / auto-pan with bit-serial gain arithmetic.
//
// Channel | Direction | Handshake         | Carries
// req     | in        | req_valid/stall   | req_type: left/right sample
// rsp     | out       | rsp_valid/stall   | rsp_type: left/right out, saturated
// csr     | in        | csr_valid/ready   | register index, 32-bit write data
//
// A request is accepted in idle; then per channel five products (depth*dip, two glide
// terms, wet*smoothed, sample*gain) go through one shared shift-add multiplier, each
// as a load state plus the 17 multiplier bits, then a channel-switch state; after
// the right channel comes the result state.
// The result register holds while rsp_stall; req_stall stays high from acceptance
// until the result has gone, and the next request is taken in the idle cycle after.
// Reset is synchronous, active high, restoring register defaults and gains.
`default_nettype none
module stereo_lfo_gain_modulator_core
   import slgm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_NEXT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   // step codes within one channel
   localparam logic [2:0] STEP_DEPTH = 3'd0;
   localparam logic [2:0] STEP_TGT   = 3'd1;
   localparam logic [2:0] STEP_OLD   = 3'd2;
   localparam logic [2:0] STEP_WET   = 3'd3;
   localparam logic [2:0] STEP_SMP   = 3'd4;

   state_type state_ff, state_in;
   cfg_type   cfg_ff, cfg_in;
   logic [31:0] phase_ff, phase_in;
   logic [16:0] gain_l_ff, gain_l_in, gain_r_ff, gain_r_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      ch_ff, ch_in;          // 0 left, 1 right
   logic [2:0] step_ff, step_in;
   logic [16:0] target_ff, target_in;
   logic [PROD_BITS-1:0] sum_ff, sum_in;
   logic [17:0] tgain_ff, tgain_in;

   logic [31:0] ch_phase;
   logic [16:0] dip, depth_c, dry_c, wet_c, old_gain;
   logic        mul_start, mul_done;
   logic signed [MCAND_BITS-1:0] mcand;
   logic [16:0] mplier;
   logic signed [PROD_BITS-1:0] product;
   logic [PROD_BITS-1:0] glide_r;
   logic [16:0] glided;
   logic signed [PROD_BITS-1:0] q;
   logic signed [PROD_BITS-1:0] r;
   logic signed [SAMPLE_BITS-1:0] sat;
   localparam logic signed [PROD_BITS-1:0] HI =
      (PROD_BITS'(1) <<< (SAMPLE_BITS - 1)) - PROD_BITS'(1);
   localparam logic signed [PROD_BITS-1:0] LO = -HI - PROD_BITS'(1);

   function automatic logic [16:0] clamp(input logic [16:0] v);
      return (v > UNITY) ? UNITY : v;
   endfunction

   assign ch_phase = ch_ff ? phase_ff + cfg_ff.phase_offset : phase_ff;
   assign depth_c  = clamp(cfg_ff.depth);
   assign dry_c    = clamp(cfg_ff.dry_gain);
   assign wet_c    = clamp(cfg_ff.wet_gain);
   assign old_gain = ch_ff ? gain_r_ff : gain_l_ff;

   slgm_lfo u_lfo (
      .phase(ch_phase), .wave_shape(cfg_ff.wave_shape), .dip(dip)
   );

   always_comb begin
      case (step_ff)
         STEP_DEPTH: begin mcand = MCAND_BITS'(dip);       mplier = depth_c; end
         STEP_TGT:   begin mcand = MCAND_BITS'(target_ff);
                           mplier = UNITY - 17'(cfg_ff.glide_coeff); end
         STEP_OLD:   begin mcand = MCAND_BITS'(old_gain);
                           mplier = {1'b0, cfg_ff.glide_coeff}; end
         STEP_WET:   begin mcand = MCAND_BITS'(wet_c);     mplier = old_gain; end
         default:    begin
            mcand  = ch_ff ? MCAND_BITS'(req_ff.right_sample)
                           : MCAND_BITS'(req_ff.left_sample);
            mplier = tgain_ff[16:0];
         end
      endcase
   end

   slgm_serial_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .mcand(mcand), .mplier(mplier), .done(mul_done), .product(product)
   );

   // Gain can reach 2.0 (bit 17); the sample term for that bit is added here.
   always_comb begin
      glide_r = (sum_ff + PROD_BITS'(product) + PROD_BITS'(32768)) >> 16;
      glided  = (glide_r > PROD_BITS'(UNITY)) ? UNITY : glide_r[16:0];
      q = product + (tgain_ff[17] ? (PROD_BITS'(mcand) <<< 17) : PROD_BITS'(0))
          + PROD_BITS'(32768);
      r = q >>> 16;   // arithmetic shift is floor
      if (r > HI) sat = HI[SAMPLE_BITS-1:0];
      else if (r < LO) sat = LO[SAMPLE_BITS-1:0];
      else sat = r[SAMPLE_BITS-1:0];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
   assign mul_start = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff; cfg_in = cfg_ff; phase_in = phase_ff;
      gain_l_in = gain_l_ff; gain_r_in = gain_r_ff; req_in = req_ff;
      rsp_in = rsp_ff; ch_in = ch_ff; step_in = step_ff;
      target_in = target_ff; sum_in = sum_ff; tgain_in = tgain_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PHASE_INC:  cfg_in.phase_increment = csr_data;
            REG_WAVE_SHAPE: cfg_in.wave_shape      = csr_data[1:0];
            REG_DEPTH:      cfg_in.depth           = csr_data[16:0];
            REG_PHASE_OFS:  cfg_in.phase_offset    = csr_data;
            REG_DRY_GAIN:   cfg_in.dry_gain        = csr_data[16:0];
            REG_WET_GAIN:   cfg_in.wet_gain        = csr_data[16:0];
            REG_GLIDE:      cfg_in.glide_coeff     = csr_data[15:0];
            default: ;
         endcase
      end
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            req_in = req_data; ch_in = 1'b0; step_in = STEP_DEPTH;
            state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_MUL;
         ST_MUL: if (mul_done) begin
            state_in = ST_LOAD;
            case (step_ff)
               STEP_DEPTH: begin
                  target_in = UNITY - 17'(product >>> 16);
                  step_in = STEP_TGT;
               end
               STEP_TGT: begin sum_in = product; step_in = STEP_OLD; end
               STEP_OLD: begin
                  if (ch_ff) gain_r_in = glided; else gain_l_in = glided;
                  step_in = STEP_WET;
               end
               STEP_WET: begin
                  tgain_in = 18'(dry_c) + 18'((product + PROD_BITS'(32768)) >>> 16);
                  step_in = STEP_SMP;
               end
               default: begin
                  if (ch_ff) rsp_in.right_out = sat; else rsp_in.left_out = sat;
                  state_in = ST_NEXT;
               end
            endcase
         end
         ST_NEXT: begin
            if (ch_ff) begin
               phase_in = phase_ff + cfg_ff.phase_increment;
               state_in = ST_OUT;
            end else begin
               ch_in = 1'b1; step_in = STEP_DEPTH; state_in = ST_LOAD;
            end
         end
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_ff <= '{phase_increment: 32'd0, wave_shape: SHAPE_SINE, depth: 17'd32768,
                     phase_offset: 32'h8000_0000, dry_gain: 17'd0, wet_gain: UNITY,
                     glide_coeff: 16'd0};
         phase_ff  <= '0;
         gain_l_ff <= UNITY;
         gain_r_ff <= UNITY;
         ch_ff     <= 1'b0;
         step_ff   <= STEP_DEPTH;
      end else begin
         state_ff  <= state_in;
         cfg_ff    <= cfg_in;
         phase_ff  <= phase_in;
         gain_l_ff <= gain_l_in;
         gain_r_ff <= gain_r_in;
         ch_ff     <= ch_in;
         step_ff   <= step_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      target_ff <= target_in;
      sum_ff    <= sum_in;
      tgain_ff  <= tgain_in;
   end
endmodule
`default_nettype wire

>>> rtl/slgm_checker.sv
// Port-level checker for the modulator core, bound to the top level.
`default_nettype none
module slgm_checker
   import slgm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed under stall");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response in cycle after request");
   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");
endmodule

bind stereo_lfo_gain_modulator_core slgm_checker u_slgm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire

>>> tb/tb_top.sv
// Testbench: stereo LFO gain modulator, predicted per request and checked field by field.
`timescale 1ns / 1ps
module tb_top;
   import slgm_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   stereo_lfo_gain_modulator_core dut (.*);

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: register copies and LFO/glide state
   logic [31:0] pm_inc, pm_ofs, pm_phase;
   logic [1:0]  pm_shape;
   logic [16:0] pm_depth, pm_dry, pm_wet, pm_left_g, pm_right_g;
   logic [15:0] pm_glide;
   logic [16:0] sine_q16 [0:256];

   req_type pending_reqs[$];
   rsp_type expected_outs[$];
   int n_fail = 0, n_checked = 0, n_sent = 0;
   int cycle = 0;
   bit calm = 0;        // no idling in the final stretch
   bit hold_off = 0;    // long receiver hold-off in progress

   // Q30 Taylor sine rounded to Q16 (own version)
   function automatic logic [16:0] taylor_sine(longint unsigned x);
      longint unsigned x2, term, r;
      longint sum;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = ($unsigned(sum) + 8192) >> 14;
      return (r > 65536) ? 17'd65536 : r[16:0];
   endfunction

   function automatic logic [16:0] sat_unity(logic [16:0] v);
      return (v > 17'd65536) ? 17'd65536 : v;
   endfunction

   function automatic longint lfo_dip(logic [31:0] ph);
      longint unsigned idx;
      longint c;
      case (pm_shape)
         SHAPE_TRIANGLE: return ph[31] ? ((64'h1_0000_0000 - ph) >> 15) : (ph >> 15);
         SHAPE_SAW:      return ph >> 16;
         SHAPE_SQUARE:   return ph[31] ? 65536 : 0;
         default: begin
            idx = (longint'(ph[29:0]) * 256) >> 30;
            case (ph[31:30])
               2'd0: c = sine_q16[256 - idx];
               2'd1: c = -longint'(sine_q16[idx]);
               2'd2: c = -longint'(sine_q16[256 - idx]);
               default: c = sine_q16[idx];
            endcase
            return (65536 - c) / 2;
         end
      endcase
   endfunction

   function automatic logic [16:0] glide_gain(logic [16:0] sm, logic [31:0] ph);
      longint unsigned tgt, r;
      tgt = 65536 - ((longint'(sat_unity(pm_depth)) * lfo_dip(ph)) >> 16);
      r = (tgt * (65536 - pm_glide) + longint'(sm) * pm_glide + 32768) >> 16;
      return (r > 65536) ? 17'd65536 : r[16:0];
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] scaled_sample(logic signed [SAMPLE_BITS-1:0] s,
                                                             logic [16:0] sm);
      longint g, q, r;
      g = sat_unity(pm_dry) + ((longint'(sat_unity(pm_wet)) * sm + 32768) >> 16);
      q = longint'(s) * g + 32768;
      r = (q >= 0) ? (q >>> 16) : -((-q + 65535) >>> 16);
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[SAMPLE_BITS-1:0];
   endfunction

   // Works out one expected result and advances the LFO
   function automatic rsp_type modulate(req_type rq);
      rsp_type o;
      pm_left_g  = glide_gain(pm_left_g, pm_phase);
      pm_right_g = glide_gain(pm_right_g, pm_phase + pm_ofs);
      o.left_out  = scaled_sample(rq.left_sample, pm_left_g);
      o.right_out = scaled_sample(rq.right_sample, pm_right_g);
      pm_phase += pm_inc;
      return o;
   endfunction

   function automatic void shadow_write(logic [2:0] idx, logic [31:0] v);
      case (idx)
         REG_PHASE_INC:  pm_inc = v;
         REG_WAVE_SHAPE: pm_shape = v[1:0];
         REG_DEPTH:      pm_depth = v[16:0];
         REG_PHASE_OFS:  pm_ofs = v;
         REG_DRY_GAIN:   pm_dry = v[16:0];
         REG_WET_GAIN:   pm_wet = v[16:0];
         REG_GLIDE:      pm_glide = v[15:0];
         default: ;
      endcase
   endfunction

   // Driver: feeds pending requests, idles in random bursts
   int tx_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            // accepted on the last rising edge (stall sampled then is still held)
         end
      end
   end

   bit req_taken;
   always @(posedge clock) req_taken <= req_valid && !req_stall && !reset;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled: hold payload
      end else if (tx_gap > 0) begin
         tx_gap <= tx_gap - 1;
         req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         tx_gap <= $urandom_range(0, 10);
         req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         req_data <= pending_reqs.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Predict at acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_outs.push_back(modulate(req_data));
         n_sent++;
      end
   end

   // Receiver stall: random bursts, or a long hold-off
   int rx_gap = 0;
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rx_gap <= $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Long receiver hold-off once the run is under way; the sender keeps offering
   initial begin
      wait (n_sent >= 300);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (600) @(negedge clock);
      hold_off <= 1'b0;
   end

   // Monitor
   always @(posedge clock) begin
      rsp_type exp_o;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outs.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            n_fail++;
         end else begin
            exp_o = expected_outs.pop_front();
            n_checked++;
            if (rsp_data.left_out !== exp_o.left_out) begin
               $error("left_out expected %0d actual %0d", exp_o.left_out, rsp_data.left_out);
               n_fail++;
            end
            if (rsp_data.right_out !== exp_o.right_out) begin
               $error("right_out expected %0d actual %0d", exp_o.right_out,
                      rsp_data.right_out);
               n_fail++;
            end
         end
      end
   end

   // Watchdog: limit set well above the expected length of the run
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 2_000_000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_write(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pending_reqs.size() > 0 || req_valid || expected_outs.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic req_type random_pair();
      req_type r;
      case ($urandom_range(0, 5))
         0: r.left_sample = 24'h7FFFFF;
         1: r.left_sample = 24'h800000;
         default: r.left_sample = 24'($urandom);
      endcase
      r.right_sample = ($urandom_range(0, 5) == 0) ? {1'($urandom_range(0, 1)), 23'h0}
                                                   : 24'($urandom);
      return r;
   endfunction

   task automatic random_setting(bit extreme);
      write_reg(REG_PHASE_INC, extreme ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0)
                                       : ($urandom >> $urandom_range(0, 20)));
      write_reg(REG_WAVE_SHAPE, $urandom_range(0, 3));
      write_reg(REG_DEPTH, extreme ? ($urandom_range(0, 1) ? 32'h1FFFF : 0)
                                   : $urandom_range(0, 70000));
      write_reg(REG_PHASE_OFS, $urandom);
      write_reg(REG_DRY_GAIN, extreme ? 32'h1FFFF : $urandom_range(0, 70000));
      write_reg(REG_WET_GAIN, extreme ? 32'h10000 : $urandom_range(0, 70000));
      write_reg(REG_GLIDE, extreme ? 32'hFFFF : $urandom_range(0, 65535));
   endtask

   initial begin
      req_type r;
      for (int k = 0; k <= 256; k++)
         sine_q16[k] = taylor_sine((64'd1686629713 * k) / 256);
      pm_inc = 0; pm_shape = SHAPE_SINE; pm_depth = 17'd32768; pm_ofs = 32'h8000_0000;
      pm_dry = 0; pm_wet = 17'd65536; pm_glide = 0; pm_phase = 0;
      pm_left_g = 17'd65536; pm_right_g = 17'd65536;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: sample extremes under reset settings, then each shape with an
      // eighth-turn phase step, then loud settings that force saturation
      for (int k = 0; k < 4; k++) begin
         r.left_sample = (k[0]) ? 24'h7FFFFF : 24'h800000;
         r.right_sample = (k[1]) ? 24'h800000 : 24'h7FFFFF;
         pending_reqs.push_back(r);
      end
      drain();
      write_reg(REG_PHASE_INC, 32'h2000_0000);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);   // unknown index, ignored
      for (int s = 0; s < 4; s++) begin
         write_reg(REG_WAVE_SHAPE, s);
         for (int k = 0; k < 4; k++) pending_reqs.push_back(random_pair());
         drain();
      end
      random_setting(1);
      for (int k = 0; k < 4; k++) pending_reqs.push_back(random_pair());
      drain();

      // Random phases; the long receiver hold-off falls in the third
      for (int ph = 0; ph < 12; ph++) begin
         random_setting(ph % 4 == 3);
         for (int k = 0; k < 100; k++) pending_reqs.push_back(random_pair());
         if (ph == 11) calm = 1;
         drain();
      end

      $display("covered %0d requests, %0d results checked over all shapes and gain extremes",
               n_sent, n_checked);
      if (n_fail == 0 && expected_outs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
